// ===== sv/tosc_pkg.sv =====
`default_nettype none

package tosc_pkg;

   // request action codes
   typedef enum logic [1:0] {
      ACT_ORIENT  = 2'd0,
      ACT_SHAPE   = 2'd1,
      ACT_CONTAIN = 2'd2
   } action_type;

   // orientation sign codes, two's complement
   typedef logic signed [1:0] sign_type;

   localparam sign_type SIGN_POS  = 2'sb01;
   localparam sign_type SIGN_ZERO = 2'sb00;
   localparam sign_type SIGN_NEG  = 2'sb11;

   // corners of a triangle
   localparam int NUM_CORNERS = 3;

endpackage : tosc_pkg

`default_nettype wire

// ===== sv/triangle_orientation_shape_contain_core.sv =====
`default_nettype none

// Exact 2D triangle predicate unit. A request (start high while busy is low) carries an
// action and four signed points a, b, c, q. Its one response is shown with rsp_valid high
// for a single cycle, once the request has passed through the register stages s1 to s6 and
// then the response register. busy is always low: a new request may enter on every
// cycle and responses leave in request order at one per cycle. The receiver cannot
// stall, so it must take each response in the cycle it is shown. The corner
// test sets the depth of seven register stages. Its products of squared lengths are about
// 4*COORD_BITS bits wide and are built from half-width partial products over three stages
// before the final compare.
// rsp_orientation_sign is always the exact sign of (b-a) x (c-a). rsp_predicate_true is
// that sign being positive (orientation), a counter-clockwise triangle with no corner
// sharper than about 18.4 degrees (shape), or q on or to the left of every edge
// (containment); an undefined action gives 0.

module triangle_orientation_shape_contain_core
   import tosc_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_action,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic signed [COORD_BITS-1:0] req_c_x,
   input  logic signed [COORD_BITS-1:0] req_c_y,
   input  logic signed [COORD_BITS-1:0] req_q_x,
   input  logic signed [COORD_BITS-1:0] req_q_y,
   output logic                         rsp_valid,
   output sign_type                     rsp_orientation_sign,
   output logic                         rsp_predicate_true
);

   // difference, product, sum and magnitude widths
   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int MW = SW - 1;
   // split of a magnitude into high and low halves
   localparam int LO = (MW + 1) / 2;
   localparam int HI = MW - LO;
   localparam int HH = 2 * HI;
   localparam int HL = HI + LO;
   localparam int LL = 2 * LO;
   // full square/product width and scaled width
   localparam int FW = 2 * MW;
   localparam int XW = FW + 4;

   localparam int NC = NUM_CORNERS;

   // stage 1: edge and query differences
   logic                 s1_valid_ff, s1_valid_in;
   action_type           s1_action_ff, s1_action_in;
   logic signed [DW-1:0] s1_ux_ff [NC], s1_ux_in [NC];
   logic signed [DW-1:0] s1_uy_ff [NC], s1_uy_in [NC];
   logic signed [DW-1:0] s1_vx_ff [NC], s1_vx_in [NC];
   logic signed [DW-1:0] s1_vy_ff [NC], s1_vy_in [NC];
   logic signed [DW-1:0] s1_fx_ff [NC], s1_fx_in [NC];
   logic signed [DW-1:0] s1_fy_ff [NC], s1_fy_in [NC];

   // stage 2: products
   logic                 s2_valid_ff;
   action_type           s2_action_ff;
   logic signed [PW-1:0] s2_ol_ff, s2_ol_in;
   logic signed [PW-1:0] s2_or_ff, s2_or_in;
   logic signed [PW-1:0] s2_kl_ff [NC], s2_kl_in [NC];
   logic signed [PW-1:0] s2_kr_ff [NC], s2_kr_in [NC];
   logic signed [PW-1:0] s2_dx_ff [NC], s2_dx_in [NC];
   logic signed [PW-1:0] s2_dy_ff [NC], s2_dy_in [NC];
   logic signed [PW-1:0] s2_sx_ff [NC], s2_sx_in [NC];
   logic signed [PW-1:0] s2_sy_ff [NC], s2_sy_in [NC];

   // stage 3: signs, dot products and squared lengths
   logic                 s3_valid_ff;
   action_type           s3_action_ff;
   sign_type             s3_sign_ff, s3_sign_in;
   logic                 s3_inside_ff, s3_inside_in;
   logic [NC-1:0]        s3_dpos_ff, s3_dpos_in;
   logic [MW-1:0]        s3_dmag_ff [NC], s3_dmag_in [NC];
   logic [MW-1:0]        s3_nrm_ff [NC], s3_nrm_in [NC];

   // stage 4: half-width partial products
   logic                 s4_valid_ff;
   action_type           s4_action_ff;
   sign_type             s4_sign_ff;
   logic                 s4_inside_ff;
   logic [NC-1:0]        s4_dpos_ff;
   logic [HH-1:0]        s4_dhh_ff [NC], s4_dhh_in [NC];
   logic [HL-1:0]        s4_dhl_ff [NC], s4_dhl_in [NC];
   logic [LL-1:0]        s4_dll_ff [NC], s4_dll_in [NC];
   logic [HH-1:0]        s4_nhh_ff [NC], s4_nhh_in [NC];
   logic [HL-1:0]        s4_nhl_ff [NC], s4_nhl_in [NC];
   logic [HL-1:0]        s4_nlh_ff [NC], s4_nlh_in [NC];
   logic [LL-1:0]        s4_nll_ff [NC], s4_nll_in [NC];

   // stage 5: full products
   logic                 s5_valid_ff;
   action_type           s5_action_ff;
   sign_type             s5_sign_ff;
   logic                 s5_inside_ff;
   logic [NC-1:0]        s5_dpos_ff;
   logic [FW-1:0]        s5_dd_ff [NC], s5_dd_in [NC];
   logic [FW-1:0]        s5_nn_ff [NC], s5_nn_in [NC];

   // stage 6: scaled products
   logic                 s6_valid_ff;
   action_type           s6_action_ff;
   sign_type             s6_sign_ff;
   logic                 s6_inside_ff;
   logic [NC-1:0]        s6_dpos_ff;
   logic [XW-1:0]        s6_ten_ff [NC], s6_ten_in [NC];
   logic [XW-1:0]        s6_nine_ff [NC], s6_nine_in [NC];

   // stage 7: response register
   logic                 rsp_valid_ff;
   sign_type             rsp_sign_ff;
   logic                 rsp_pred_ff, rsp_pred_in;
   logic [NC-1:0]        sharp;

   // the pipeline never stalls
   assign busy = 1'b0;

   // accept a request every cycle
   assign s1_valid_in  = start & ~busy;
   assign s1_action_in = action_type'(req_action);

   // form the edge vectors: corner a uses b-a and c-a, b uses c-b and a-b, c uses a-c and b-c
   always_comb begin
      s1_ux_in[0] = DW'(req_b_x) - DW'(req_a_x);
      s1_uy_in[0] = DW'(req_b_y) - DW'(req_a_y);
      s1_vx_in[0] = DW'(req_c_x) - DW'(req_a_x);
      s1_vy_in[0] = DW'(req_c_y) - DW'(req_a_y);
      s1_ux_in[1] = DW'(req_c_x) - DW'(req_b_x);
      s1_uy_in[1] = DW'(req_c_y) - DW'(req_b_y);
      s1_vx_in[1] = DW'(req_a_x) - DW'(req_b_x);
      s1_vy_in[1] = DW'(req_a_y) - DW'(req_b_y);
      s1_ux_in[2] = DW'(req_a_x) - DW'(req_c_x);
      s1_uy_in[2] = DW'(req_a_y) - DW'(req_c_y);
      s1_vx_in[2] = DW'(req_b_x) - DW'(req_c_x);
      s1_vy_in[2] = DW'(req_b_y) - DW'(req_c_y);
      s1_fx_in[0] = DW'(req_q_x) - DW'(req_a_x);
      s1_fy_in[0] = DW'(req_q_y) - DW'(req_a_y);
      s1_fx_in[1] = DW'(req_q_x) - DW'(req_b_x);
      s1_fy_in[1] = DW'(req_q_y) - DW'(req_b_y);
      s1_fx_in[2] = DW'(req_q_x) - DW'(req_c_x);
      s1_fy_in[2] = DW'(req_q_y) - DW'(req_c_y);
   end

   // multiply: orientation cross terms, edge-query cross terms, dot terms, squares
   always_comb begin
      s2_ol_in = PW'(s1_ux_ff[0]) * PW'(s1_vy_ff[0]);
      s2_or_in = PW'(s1_uy_ff[0]) * PW'(s1_vx_ff[0]);
      for (int i = 0; i < NC; i++) begin
         s2_kl_in[i] = PW'(s1_ux_ff[i]) * PW'(s1_fy_ff[i]);
         s2_kr_in[i] = PW'(s1_uy_ff[i]) * PW'(s1_fx_ff[i]);
         s2_dx_in[i] = PW'(s1_ux_ff[i]) * PW'(s1_vx_ff[i]);
         s2_dy_in[i] = PW'(s1_uy_ff[i]) * PW'(s1_vy_ff[i]);
         s2_sx_in[i] = PW'(s1_ux_ff[i]) * PW'(s1_ux_ff[i]);
         s2_sy_in[i] = PW'(s1_uy_ff[i]) * PW'(s1_uy_ff[i]);
      end
   end

   // reduce: orientation sign, containment, dot products and squared edge lengths
   always_comb begin
      logic signed [SW-1:0] odiff;
      logic signed [SW-1:0] dsum;
      logic signed [SW-1:0] nsum;
      odiff = SW'(s2_ol_ff) - SW'(s2_or_ff);
      if (odiff[SW-1]) begin
         s3_sign_in = SIGN_NEG;
      end else if (odiff == '0) begin
         s3_sign_in = SIGN_ZERO;
      end else begin
         s3_sign_in = SIGN_POS;
      end
      s3_inside_in = 1'b1;
      for (int i = 0; i < NC; i++) begin
         if (s2_kl_ff[i] < s2_kr_ff[i]) begin
            s3_inside_in = 1'b0;
         end
         dsum = SW'(s2_dx_ff[i]) + SW'(s2_dy_ff[i]);
         nsum = SW'(s2_sx_ff[i]) + SW'(s2_sy_ff[i]);
         s3_dpos_in[i] = ~dsum[SW-1] && (dsum != '0);
         s3_dmag_in[i] = dsum[MW-1:0];
         s3_nrm_in[i]  = nsum[MW-1:0];
      end
   end

   // split into halves: corner i pairs edge i with edge i+2 (its other side, reversed)
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         s4_dhh_in[i] = HH'(s3_dmag_ff[i][MW-1:LO]) * HH'(s3_dmag_ff[i][MW-1:LO]);
         s4_dhl_in[i] = HL'(s3_dmag_ff[i][MW-1:LO]) * HL'(s3_dmag_ff[i][LO-1:0]);
         s4_dll_in[i] = LL'(s3_dmag_ff[i][LO-1:0]) * LL'(s3_dmag_ff[i][LO-1:0]);
         s4_nhh_in[i] = HH'(s3_nrm_ff[i][MW-1:LO])
                      * HH'(s3_nrm_ff[(i + 2) % NC][MW-1:LO]);
         s4_nhl_in[i] = HL'(s3_nrm_ff[i][MW-1:LO])
                      * HL'(s3_nrm_ff[(i + 2) % NC][LO-1:0]);
         s4_nlh_in[i] = HL'(s3_nrm_ff[i][LO-1:0])
                      * HL'(s3_nrm_ff[(i + 2) % NC][MW-1:LO]);
         s4_nll_in[i] = LL'(s3_nrm_ff[i][LO-1:0])
                      * LL'(s3_nrm_ff[(i + 2) % NC][LO-1:0]);
      end
   end

   // assemble the full products from the partial products
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         s5_dd_in[i] = (FW'(s4_dhh_ff[i]) << (2 * LO))
                     + (FW'(s4_dhl_ff[i]) << (LO + 1))
                     + FW'(s4_dll_ff[i]);
         s5_nn_in[i] = (FW'(s4_nhh_ff[i]) << (2 * LO))
                     + ((FW'(s4_nhl_ff[i]) + FW'(s4_nlh_ff[i])) << LO)
                     + FW'(s4_nll_ff[i]);
      end
   end

   // scale: 10*d^2 and 9*|u|^2*|v|^2
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         s6_ten_in[i]  = (XW'(s5_dd_ff[i]) << 3) + (XW'(s5_dd_ff[i]) << 1);
         s6_nine_in[i] = (XW'(s5_nn_ff[i]) << 3) + XW'(s5_nn_ff[i]);
      end
   end

   // compare corners and select the verdict for the action
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         sharp[i] = s6_dpos_ff[i] && (s6_ten_ff[i] > s6_nine_ff[i]);
      end
      unique case (s6_action_ff)
         ACT_ORIENT:  rsp_pred_in = (s6_sign_ff == SIGN_POS);
         ACT_SHAPE:   rsp_pred_in = (s6_sign_ff == SIGN_POS) && (sharp == '0);
         ACT_CONTAIN: rsp_pred_in = s6_inside_ff;
         default:     rsp_pred_in = 1'b0;
      endcase
   end

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= s6_valid_ff;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      s1_action_ff <= s1_action_in;
      s2_action_ff <= s1_action_ff;
      s3_action_ff <= s2_action_ff;
      s4_action_ff <= s3_action_ff;
      s5_action_ff <= s4_action_ff;
      s6_action_ff <= s5_action_ff;

      s2_ol_ff <= s2_ol_in;
      s2_or_ff <= s2_or_in;

      s3_sign_ff   <= s3_sign_in;
      s3_inside_ff <= s3_inside_in;
      s3_dpos_ff   <= s3_dpos_in;
      s4_sign_ff   <= s3_sign_ff;
      s4_inside_ff <= s3_inside_ff;
      s4_dpos_ff   <= s3_dpos_ff;
      s5_sign_ff   <= s4_sign_ff;
      s5_inside_ff <= s4_inside_ff;
      s5_dpos_ff   <= s4_dpos_ff;
      s6_sign_ff   <= s5_sign_ff;
      s6_inside_ff <= s5_inside_ff;
      s6_dpos_ff   <= s5_dpos_ff;

      rsp_sign_ff <= s6_sign_ff;
      rsp_pred_ff <= rsp_pred_in;

      for (int i = 0; i < NC; i++) begin
         s1_ux_ff[i]   <= s1_ux_in[i];
         s1_uy_ff[i]   <= s1_uy_in[i];
         s1_vx_ff[i]   <= s1_vx_in[i];
         s1_vy_ff[i]   <= s1_vy_in[i];
         s1_fx_ff[i]   <= s1_fx_in[i];
         s1_fy_ff[i]   <= s1_fy_in[i];
         s2_kl_ff[i]   <= s2_kl_in[i];
         s2_kr_ff[i]   <= s2_kr_in[i];
         s2_dx_ff[i]   <= s2_dx_in[i];
         s2_dy_ff[i]   <= s2_dy_in[i];
         s2_sx_ff[i]   <= s2_sx_in[i];
         s2_sy_ff[i]   <= s2_sy_in[i];
         s3_dmag_ff[i] <= s3_dmag_in[i];
         s3_nrm_ff[i]  <= s3_nrm_in[i];
         s4_dhh_ff[i]  <= s4_dhh_in[i];
         s4_dhl_ff[i]  <= s4_dhl_in[i];
         s4_dll_ff[i]  <= s4_dll_in[i];
         s4_nhh_ff[i]  <= s4_nhh_in[i];
         s4_nhl_ff[i]  <= s4_nhl_in[i];
         s4_nlh_ff[i]  <= s4_nlh_in[i];
         s4_nll_ff[i]  <= s4_nll_in[i];
         s5_dd_ff[i]   <= s5_dd_in[i];
         s5_nn_ff[i]   <= s5_nn_in[i];
         s6_ten_ff[i]  <= s6_ten_in[i];
         s6_nine_ff[i] <= s6_nine_in[i];
      end
   end

   // drive the response
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_orientation_sign = rsp_sign_ff;
   assign rsp_predicate_true   = rsp_pred_ff;

endmodule : triangle_orientation_shape_contain_core

`default_nettype wire
